FILE: design/tpd_pkg.sv
// ----------------------------------------------------------------------------
// tpd_pkg: shared types and constants of the three-axis PID drive
// Sequencer states, arithmetic unit handshakes, register indexes and the
// fixed-point constants of the controller.
// ----------------------------------------------------------------------------
package tpd_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ERR,
      ST_INTEG,
      ST_P,
      ST_I,
      ST_IDIV,
      ST_D1,
      ST_D2,
      ST_DDIV,
      ST_NEXT,
      ST_HEAD,
      ST_HDIV,
      ST_OUT,
      ST_OWAIT,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic        start;
      logic [63:0] a;
      logic [19:0] b;
   } mul_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] product;
   } mul_rsp_type;

   typedef struct packed {
      logic        start;
      logic [63:0] num;
      logic [31:0] den;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quot;
   } div_rsp_type;

   localparam logic [1:0] REG_KP = 2'd0;
   localparam logic [1:0] REG_KI = 2'd1;
   localparam logic [1:0] REG_KD = 2'd2;

   localparam logic [15:0] KP_RESET = 16'd98;
   localparam logic [15:0] KI_RESET = 16'd86;
   localparam logic [15:0] KD_RESET = 16'd0;

   localparam logic [31:0] I_DIVISOR    = 32'd4096000000;
   localparam logic [19:0] US_PER_S     = 20'd1000000;
   localparam logic [31:0] HEAD_DIVISOR = 32'd225;
   localparam logic [63:0] Q_ONE        = 64'd16384;

endpackage

FILE: design/tpd_mul.sv
// ----------------------------------------------------------------------------
// tpd_mul: bit-serial shift-add multiplier
// Unsigned product of a 64-bit multiplicand and a 20-bit multiplier, one
// multiplier bit per cycle; finishes as soon as the remaining bits are zero.
// ----------------------------------------------------------------------------
module tpd_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  tpd_pkg::mul_req_type req,
   output tpd_pkg::mul_rsp_type rsp
);
   import tpd_pkg::*;

   logic [63:0] a_ff, a_in;
   logic [19:0] b_ff, b_in;
   logic [63:0] acc_ff, acc_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         a_in    = req.a;
         b_in    = req.b;
         acc_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            if (b_ff[0]) begin
               acc_in = acc_ff + a_ff;
            end
            a_in = {a_ff[62:0], 1'b0};
            b_in = {1'b0, b_ff[19:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done    = done_ff;
   assign rsp.product = acc_ff;

endmodule

FILE: design/tpd_div.sv
// ----------------------------------------------------------------------------
// tpd_div: bit-serial restoring divider
// Unsigned 64-bit by 32-bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tpd_div (
   input  logic                 clock,
   input  logic                 reset,
   input  tpd_pkg::div_req_type req,
   output tpd_pkg::div_rsp_type rsp
);
   import tpd_pkg::*;

   logic [63:0] num_ff, num_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;
   logic [32:0] diff;

   assign trial = {rem_ff, num_ff[63]};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         num_in  = req.num;
         rem_in  = '0;
         den_in  = req.den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // The partial remainder stays below the divisor, so 32 bits hold it.
         if (!diff[32]) begin
            rem_in = diff[31:0];
            num_in = {num_ff[62:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            num_in = {num_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = num_ff;

endmodule

FILE: design/three_axis_pid_drive_with_heading_hold.sv
// An enabled word runs through serial divisions (one or two per axis, one for
// heading hold, three output scalings) and bit-serial multiplies that last as
// long as their operand bits. Words are taken only while the sequencer is idle, so
// an enabled word must reach the output register; a disabled word leaves it idle.
// Reset (synchronous, active high) clears speeds, errors, integrals, held
// heading and enable history, and loads the default gains.
// ----------------------------------------------------------------------------
// three_axis_pid_drive_with_heading_hold: incremental PID drive, three axes
// A sequencer runs one PID update per axis on a shared serial multiplier and
// divider, applies heading hold to rotation and scales the outputs.
// ----------------------------------------------------------------------------
module three_axis_pid_drive_with_heading_hold (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // strafe[15:0], forward[31:16], rotate[47:32], heading[79:48],
   // elapsed_us[99:80], full_speed[100], drive_enabled[101], zero pad
   input  logic [103:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // drive_strafe[15:0], drive_forward[31:16], drive_rotate[47:32]
   output logic [47:0]  rsp_tdata,
   input  logic         csr_wr_en,
   input  logic [1:0]   csr_addr,
   input  logic [15:0]  csr_wr_data
);
   import tpd_pkg::*;

   state_type state_ff, state_in;
   logic [1:0]         ax_ff, ax_in;
   logic signed [15:0] sx_ff, sx_in, fy_ff, fy_in, rz_ff, rz_in;
   logic signed [31:0] hd_ff, hd_in, held_ff, held_in;
   logic [19:0]        dt_ff, dt_in;
   logic               full_ff, full_in;
   logic               was_en_ff, was_en_in;
   logic signed [15:0] e_ff, e_in;
   logic signed [16:0] delta_ff, delta_in;
   logic signed [63:0] acc_ff, acc_in, corr_ff, corr_in;
   logic               neg_ff, neg_in;
   logic signed [15:0] speed_ff [3];
   logic signed [15:0] speed_in [3];
   logic signed [15:0] prev_ff [3];
   logic signed [15:0] prev_in [3];
   logic signed [47:0] integ_ff [3];
   logic signed [47:0] integ_in [3];
   logic [15:0]        ores_ff [3];
   logic [15:0]        ores_in [3];
   logic [15:0]        kp_ff, kp_in, ki_ff, ki_in, kd_ff, kd_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [47:0]        rsp_data_ff, rsp_data_in;

   mul_req_type mul_req;
   mul_rsp_type mul_rsp;
   div_req_type div_req;
   div_rsp_type div_rsp;

   logic               req_acc;
   logic signed [15:0] cmd_sel, spd_sel;
   logic signed [17:0] diff18;
   logic signed [15:0] e_sat;
   logic signed [63:0] mul_signed, div_signed;
   logic signed [48:0] integ_sum;
   logic signed [63:0] speed_sum;
   logic signed [15:0] speed_clamped;
   logic signed [32:0] head_diff;
   logic [32:0]        head_mag;
   logic               hold;
   logic [14:0]        spd_mag;

   tpd_mul u_mul (.clock(clock), .reset(reset), .req(mul_req), .rsp(mul_rsp));
   tpd_div u_div (.clock(clock), .reset(reset), .req(div_req), .rsp(div_rsp));

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      unique case (ax_ff)
         2'd0:    begin cmd_sel = sx_ff; spd_sel = speed_ff[0]; end
         2'd1:    begin cmd_sel = fy_ff; spd_sel = speed_ff[1]; end
         default: begin cmd_sel = rz_ff; spd_sel = speed_ff[2]; end
      endcase
   end

   assign diff18 = {{2{cmd_sel[15]}}, cmd_sel} - {{2{spd_sel[15]}}, spd_sel};
   always_comb begin
      if (diff18 > 18'sd32767) begin
         e_sat = 16'sh7FFF;
      end else if (diff18 < -18'sd32768) begin
         e_sat = 16'sh8000;
      end else begin
         e_sat = diff18[15:0];
      end
   end

   assign mul_signed = neg_ff ? -$signed(mul_rsp.product) : $signed(mul_rsp.product);
   assign div_signed = neg_ff ? -$signed(div_rsp.quot) : $signed(div_rsp.quot);
   assign integ_sum  = {integ_ff[ax_ff][47], integ_ff[ax_ff]} + mul_signed[48:0];

   assign speed_sum = {{48{spd_sel[15]}}, spd_sel} + acc_ff
                      + ((ax_ff == 2'd2) ? corr_ff : 64'sd0);
   always_comb begin
      if (speed_sum > $signed(Q_ONE)) begin
         speed_clamped = 16'sd16384;
      end else if (speed_sum < -$signed(Q_ONE)) begin
         speed_clamped = -16'sd16384;
      end else begin
         speed_clamped = speed_sum[15:0];
      end
   end

   assign head_diff = {held_ff[31], held_ff} - {hd_ff[31], hd_ff};
   assign head_mag  = head_diff[32] ? 33'(-head_diff) : 33'(head_diff);
   assign hold = (sx_ff >= -16'sd1310) && (sx_ff <= 16'sd1310)
              && (rz_ff >= -16'sd163) && (rz_ff <= 16'sd163)
              && ((fy_ff > 16'sd8192) || (fy_ff < -16'sd8192));
   assign spd_mag = spd_sel[15] ? 15'(-spd_sel) : spd_sel[14:0];

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_acc && req_tdata[101]) state_in = ST_ERR;
         ST_ERR:   state_in = ST_INTEG;
         ST_INTEG: if (mul_rsp.done) state_in = ST_P;
         ST_P:     if (mul_rsp.done) state_in = ST_I;
         ST_I:     if (mul_rsp.done) state_in = ST_IDIV;
         ST_IDIV: begin
            if (div_rsp.done) state_in = (dt_ff != '0) ? ST_D1 : ST_NEXT;
         end
         ST_D1:    if (mul_rsp.done) state_in = ST_D2;
         ST_D2:    if (mul_rsp.done) state_in = ST_DDIV;
         ST_DDIV:  if (div_rsp.done) state_in = ST_NEXT;
         ST_NEXT: begin
            priority case (ax_ff)
               2'd0:    state_in = ST_ERR;
               2'd1:    state_in = ST_HEAD;
               default: state_in = ST_OUT;
            endcase
         end
         ST_HEAD:  state_in = hold ? ST_HDIV : ST_ERR;
         ST_HDIV:  if (div_rsp.done) state_in = ST_ERR;
         ST_OUT:   state_in = ST_OWAIT;
         ST_OWAIT: if (div_rsp.done) state_in = (ax_ff == 2'd2) ? ST_SEND : ST_OUT;
         ST_SEND:  if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Datapath and unit requests.
   always_comb begin
      ax_in     = ax_ff;
      sx_in     = sx_ff;
      fy_in     = fy_ff;
      rz_in     = rz_ff;
      hd_in     = hd_ff;
      dt_in     = dt_ff;
      full_in   = full_ff;
      held_in   = held_ff;
      was_en_in = was_en_ff;
      e_in      = e_ff;
      delta_in  = delta_ff;
      acc_in    = acc_ff;
      corr_in   = corr_ff;
      neg_in    = neg_ff;
      speed_in  = speed_ff;
      prev_in   = prev_ff;
      integ_in  = integ_ff;
      ores_in   = ores_ff;
      kp_in     = kp_ff;
      ki_in     = ki_ff;
      kd_in     = kd_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      mul_req   = '0;
      div_req   = '0;

      if (csr_wr_en) begin
         unique case (csr_addr)
            REG_KP:  kp_in = csr_wr_data;
            REG_KI:  ki_in = csr_wr_data;
            REG_KD:  kd_in = csr_wr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               sx_in   = req_tdata[15:0];
               fy_in   = req_tdata[31:16];
               rz_in   = req_tdata[47:32];
               hd_in   = req_tdata[79:48];
               dt_in   = req_tdata[99:80];
               full_in = req_tdata[100];
               ax_in   = 2'd0;
               corr_in = '0;
               if (req_tdata[101]) begin
                  if (!was_en_ff) held_in = req_tdata[79:48];
                  was_en_in = 1'b1;
               end else begin
                  was_en_in = 1'b0;
               end
            end
         end
         ST_ERR: begin
            e_in     = e_sat;
            delta_in = {e_sat[15], e_sat} - {prev_ff[ax_ff][15], prev_ff[ax_ff]};
            neg_in   = prev_ff[ax_ff][15];
            mul_req.start = 1'b1;
            mul_req.a = 64'(prev_ff[ax_ff][15] ? 17'(-{prev_ff[ax_ff][15], prev_ff[ax_ff]})
                                               : 17'({1'b0, prev_ff[ax_ff]}));
            mul_req.b = dt_ff;
         end
         ST_INTEG: begin
            if (mul_rsp.done) begin
               if (integ_sum[48] != integ_sum[47]) begin
                  integ_in[ax_ff] = integ_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
               end else begin
                  integ_in[ax_ff] = integ_sum[47:0];
               end
               neg_in = e_ff[15];
               mul_req.start = 1'b1;
               mul_req.a = 64'(e_ff[15] ? 17'(-{e_ff[15], e_ff}) : 17'({1'b0, e_ff}));
               mul_req.b = {4'd0, kp_ff};
            end
         end
         ST_P: begin
            if (mul_rsp.done) begin
               acc_in = neg_ff ? -$signed({12'd0, mul_rsp.product[63:12]})
                               : $signed({12'd0, mul_rsp.product[63:12]});
               neg_in = integ_ff[ax_ff][47];
               mul_req.start = 1'b1;
               // The magnitude of the most negative integral needs all 48 bits unsigned.
               mul_req.a = {16'd0, (integ_ff[ax_ff][47] ? 48'(-integ_ff[ax_ff])
                                                        : 48'(integ_ff[ax_ff]))};
               mul_req.b = {4'd0, ki_ff};
            end
         end
         ST_I: begin
            if (mul_rsp.done) begin
               div_req.start = 1'b1;
               div_req.num   = mul_rsp.product;
               div_req.den   = I_DIVISOR;
            end
         end
         ST_IDIV: begin
            if (div_rsp.done) begin
               acc_in = acc_ff + div_signed;
               if (dt_ff != '0) begin
                  neg_in = delta_ff[16];
                  mul_req.start = 1'b1;
                  mul_req.a = 64'(delta_ff[16] ? 17'(-delta_ff) : 17'(delta_ff));
                  mul_req.b = {4'd0, kd_ff};
               end
            end
         end
         ST_D1: begin
            if (mul_rsp.done) begin
               mul_req.start = 1'b1;
               mul_req.a     = mul_rsp.product;
               mul_req.b     = US_PER_S;
            end
         end
         ST_D2: begin
            if (mul_rsp.done) begin
               div_req.start = 1'b1;
               div_req.num   = mul_rsp.product;
               div_req.den   = {dt_ff, 12'd0};
            end
         end
         ST_DDIV: begin
            if (div_rsp.done) acc_in = acc_ff + div_signed;
         end
         ST_NEXT: begin
            speed_in[ax_ff] = speed_clamped;
            prev_in[ax_ff]  = e_ff;
            priority case (ax_ff)
               2'd0:    ax_in = 2'd1;
               2'd1:    ax_in = 2'd1;
               default: ax_in = 2'd0;
            endcase
         end
         ST_HEAD: begin
            if (hold) begin
               neg_in = head_diff[32];
               div_req.start = 1'b1;
               div_req.num   = 64'({head_mag, 3'd0});
               div_req.den   = HEAD_DIVISOR;
            end else begin
               held_in = hd_ff;
               corr_in = '0;
               ax_in   = 2'd2;
            end
         end
         ST_HDIV: begin
            if (div_rsp.done) begin
               corr_in = div_signed;
               ax_in   = 2'd2;
            end
         end
         ST_OUT: begin
            neg_in = spd_sel[15];
            div_req.start = 1'b1;
            if (ax_ff == 2'd0) begin
               div_req.num = full_ff ? 64'({spd_mag, 2'd0} + {1'b0, spd_mag, 1'b0})
                                     : 64'({1'b0, spd_mag, 1'b0} + {2'd0, spd_mag});
               div_req.den = 32'd5;
            end else begin
               div_req.num = 64'({spd_mag, 3'd0} + {3'd0, spd_mag});
               div_req.den = full_ff ? 32'd10 : 32'd20;
            end
         end
         ST_OWAIT: begin
            if (div_rsp.done) begin
               if ((ax_ff == 2'd0) && (div_signed > $signed(Q_ONE))) begin
                  ores_in[ax_ff] = 16'd16384;
               end else begin
                  ores_in[ax_ff] = div_signed[15:0];
               end
               if (ax_ff != 2'd2) ax_in = ax_ff + 2'd1;
            end
         end
         ST_SEND: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {ores_ff[2], ores_ff[1], ores_ff[0]};
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      sx_ff    <= sx_in;
      fy_ff    <= fy_in;
      rz_ff    <= rz_in;
      hd_ff    <= hd_in;
      dt_ff    <= dt_in;
      full_ff  <= full_in;
      e_ff     <= e_in;
      delta_ff <= delta_in;
      acc_ff   <= acc_in;
      corr_ff  <= corr_in;
      neg_ff   <= neg_in;
      ores_ff  <= ores_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         ax_ff        <= 2'd0;
         held_ff      <= '0;
         was_en_ff    <= 1'b0;
         speed_ff     <= '{default: '0};
         prev_ff      <= '{default: '0};
         integ_ff     <= '{default: '0};
         kp_ff        <= KP_RESET;
         ki_ff        <= KI_RESET;
         kd_ff        <= KD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ax_ff        <= ax_in;
         held_ff      <= held_in;
         was_en_ff    <= was_en_in;
         speed_ff     <= speed_in;
         prev_ff      <= prev_in;
         integ_ff     <= integ_in;
         kp_ff        <= kp_in;
         ki_ff        <= ki_in;
         kd_ff        <= kd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: tb/three_axis_pid_drive_with_heading_hold_tb.sv
// ----------------------------------------------------------------------------
// three_axis_pid_drive_with_heading_hold_tb: self-checking bench of the drive
// A bit-accurate software copy of the three-axis PID and heading hold
// predicts each drive word. Directed corner words come first, then random
// ticks under several gain settings and idle/stall patterns on both streams.
// ----------------------------------------------------------------------------
module three_axis_pid_drive_with_heading_hold_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tpd_pkg::*;

   localparam int IDLE_LIMIT   = 40000;
   localparam int SETTLE_WAIT  = 1200;
   localparam int RANDOM_WORDS = 1400;

   typedef struct packed {
      logic signed [15:0] rotate;
      logic signed [15:0] forward;
      logic signed [15:0] strafe;
   } drive_word_type;

   class pid_drive_model;
      longint kp, ki, kd;
      longint speed[3];
      longint last_err[3];
      longint integ_sum[3];
      longint held;
      bit     enabled_before;
      drive_word_type pending[$];

      function new();
         clear();
      endfunction

      function void clear();
         kp = KP_RESET; ki = KI_RESET; kd = KD_RESET;
         for (int a = 0; a < 3; a++) begin
            speed[a] = 0; last_err[a] = 0; integ_sum[a] = 0;
         end
         held = 0;
         enabled_before = 0;
         pending.delete();
      endfunction

      function void set_gain(logic [1:0] idx, logic [15:0] val);
         case (idx)
            REG_KP: kp = val;
            REG_KI: ki = val;
            REG_KD: kd = val;
            default: ;
         endcase
      endfunction

      function longint limit(longint v, longint lo, longint hi);
         return v < lo ? lo : (v > hi ? hi : v);
      endfunction

      function longint mag(longint v);
         return v < 0 ? -v : v;
      endfunction

      // Returns the speed increment of one axis and updates its history.
      function longint axis_step(int a, longint cmd, longint dt);
         longint div_i, e, sum, p, i, d;
         div_i = 64'sd4096000000;
         e = limit(cmd - speed[a], -32768, 32767);
         sum = limit(integ_sum[a] + last_err[a] * dt,
                     -64'sd140737488355328, 64'sd140737488355327);
         integ_sum[a] = sum;
         p = (kp * e) / 4096;
         i = ki * (sum / div_i) + (ki * (sum % div_i)) / div_i;
         d = 0;
         if (dt != 0) d = (kd * (e - last_err[a]) * 1000000) / (4096 * dt);
         last_err[a] = e;
         return p + i + d;
      endfunction

      function void note_word(logic [103:0] w);
         longint sx, fy, rz, hd, dt, nx, ny, nz, corr, ox, oy, oz;
         bit full;
         drive_word_type r;
         sx = $signed(w[15:0]);
         fy = $signed(w[31:16]);
         rz = $signed(w[47:32]);
         hd = $signed(w[79:48]);
         dt = w[99:80];
         full = w[100];
         if (!w[101]) begin
            enabled_before = 0;
            return;
         end
         if (!enabled_before) held = hd;
         enabled_before = 1;
         nx = speed[0] + axis_step(0, sx, dt);
         ny = speed[1] + axis_step(1, fy, dt);
         corr = 0;
         if (mag(sx) <= 1310 && mag(rz) <= 163 && mag(fy) > 8192)
            corr = ((held - hd) * 8) / 225;
         else
            held = hd;
         nz = speed[2] + corr + axis_step(2, rz, dt);
         speed[0] = limit(nx, -16384, 16384);
         speed[1] = limit(ny, -16384, 16384);
         speed[2] = limit(nz, -16384, 16384);
         if (full) begin
            ox = (speed[0] * 6) / 5;
            oy = (speed[1] * 9) / 10;
            oz = (speed[2] * 9) / 10;
         end else begin
            ox = (speed[0] * 3) / 5;
            oy = (speed[1] * 9) / 20;
            oz = (speed[2] * 9) / 20;
         end
         if (ox > 16384) ox = 16384;
         r.strafe = ox[15:0];
         r.forward = oy[15:0];
         r.rotate = oz[15:0];
         pending.push_back(r);
      endfunction

      // Pops the oldest expected word; returns 0 when none is waiting.
      function bit check_word(output drive_word_type want);
         if (pending.size() == 0) return 0;
         want = pending.pop_front();
         return 1;
      endfunction
   endclass

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [103:0]  req_tdata;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [47:0]   rsp_tdata;
   logic          csr_wr_en;
   logic [1:0]    csr_addr;
   logic [15:0]   csr_wr_data;

   pid_drive_model drive_model = new();
   int            error_count;
   int            words_sent;
   int            words_checked;
   int            idle_cycles;
   int            send_idle_pct;
   int            recv_stall_pct;

   three_axis_pid_drive_with_heading_hold dut (.*);

   always begin
      clock = 1'b1; #2;
      clock = 1'b0; #2;
   end

   task automatic report(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   // Result side: check every accepted word, then pick next cycle's ready.
   always @(posedge clock) begin
      drive_word_type want;
      drive_word_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (!drive_model.check_word(want)) begin
            report($sformatf("unexpected drive word %h", rsp_tdata));
         end else begin
            words_checked++;
            if (got.strafe !== want.strafe)
               report($sformatf("drive_strafe %0d, expected %0d", got.strafe, want.strafe));
            if (got.forward !== want.forward)
               report($sformatf("drive_forward %0d, expected %0d", got.forward,
                                want.forward));
            if (got.rotate !== want.rotate)
               report($sformatf("drive_rotate %0d, expected %0d", got.rotate, want.rotate));
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
         $display("three_axis_pid_drive_with_heading_hold_tb: errors");
         $finish;
      end
   end

   task automatic send_word(input logic [103:0] w);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata <= w;
      do @(posedge clock); while (!req_tready);
      drive_model.note_word(w);
      words_sent++;
      gap = 0;
      if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (drive_model.pending.size() != 0) @(posedge clock);
      // A disabled word leaves nothing to wait for, so give the sequencer time.
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic write_gain(input logic [1:0] idx, input logic [15:0] val);
      csr_wr_en <= 1'b1;
      csr_addr <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      drive_model.set_gain(idx, val);
   endtask

   function automatic logic [103:0] make_word(logic [15:0] sx, logic [15:0] fy,
                                             logic [15:0] rz, logic [31:0] hd,
                                             logic [19:0] dt, logic full, logic en);
      return {2'b00, en, full, dt, hd, rz, fy, sx};
   endfunction

   function automatic logic [15:0] rand_cmd();
      int r;
      r = $urandom_range(99);
      if (r < 8) return 16'($urandom);
      if (r < 16) return ($urandom_range(1)) ? 16'sd16384 : -16'sd16384;
      return 16'($urandom_range(32768) - 16384);
   endfunction

   function automatic logic [19:0] rand_dt();
      int r;
      r = $urandom_range(99);
      if (r < 3) return 20'd0;
      if (r < 10) return 20'($urandom);
      return 20'($urandom_range(1, 40000));
   endfunction

   task automatic random_words(input int count);
      logic [15:0] sx, fy, rz;
      logic [31:0] hd;
      int          hold_base;
      hold_base = $urandom;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 40) begin
            // Straight driving with a drifting gyro exercises heading hold.
            sx = 16'($urandom_range(2620) - 1310);
            rz = 16'($urandom_range(326) - 163);
            fy = $urandom_range(1) ? 16'($urandom_range(8193, 16384))
                                   : 16'(-$urandom_range(8193, 16384));
            if ($urandom_range(9) == 0) sx = rand_cmd();
            hold_base += $urandom_range(2000) - 1000;
            hd = hold_base;
         end else begin
            sx = rand_cmd(); fy = rand_cmd(); rz = rand_cmd();
            hd = ($urandom_range(3) == 0) ? $urandom : hold_base + $urandom_range(20000);
         end
         if ($urandom_range(99) == 0) hd = {1'($urandom_range(1)), 31'h0};
         send_word(make_word(sx, fy, rz, hd, rand_dt(), 1'($urandom_range(1)),
                             $urandom_range(99) >= 8));
      end
   endtask

   initial begin
      logic [15:0] gains[6][3];
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_wr_en = 1'b0;
      csr_addr = REG_KP;
      csr_wr_data = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      error_count = 0;
      words_sent = 0;
      words_checked = 0;
      idle_cycles = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed corners under the reset gains.
      send_word(make_word(16'sd16384, 16'sd16384, 16'sd16384, 32'h7fffffff, 20'hfffff,
                          1'b1, 1'b1));
      send_word(make_word(-16'sd16384, -16'sd16384, -16'sd16384, 32'h80000000, 20'd1,
                          1'b0, 1'b1));
      send_word(make_word(16'h7fff, 16'h8000, 16'h7fff, 32'h0, 20'd0, 1'b1, 1'b1));
      send_word(make_word(16'h8000, 16'h7fff, 16'h8000, 32'hffffffff, 20'd1000, 1'b1, 1'b1));
      send_word(make_word(16'h0, 16'sd12000, 16'h0, 32'd5000, 20'd2000, 1'b1, 1'b0));
      send_word(make_word(16'h0, 16'sd12000, 16'h0, 32'd5000, 20'd2000, 1'b1, 1'b1));
      send_word(make_word(16'sd1310, 16'sd8193, -16'sd163, 32'd90000, 20'd2000, 1'b1, 1'b1));
      send_word(make_word(-16'sd1310, -16'sd16384, 16'sd163, -32'sd90000, 20'd2000,
                          1'b0, 1'b1));
      send_word(make_word(16'sd1311, 16'sd16384, 16'sd0, 32'd0, 20'd2000, 1'b1, 1'b1));
      send_word(make_word(16'sd0, 16'sd8192, 16'sd164, 32'd400, 20'd2000, 1'b1, 1'b1));
      send_word(make_word(-16'sd16384, 16'sd0, 16'sd0, 32'd0, 20'd0, 1'b1, 1'b1));
      send_word(make_word(16'sd16384, 16'sd0, 16'sd0, 32'd0, 20'd5, 1'b0, 1'b1));
      send_word(make_word(16'hffff, 16'h0, 16'h0, 32'h55555555, 20'haaaaa, 1'b1, 1'b0));
      send_word(make_word(16'h5555, 16'haaaa, 16'h5555, 32'haaaaaaaa, 20'h55555, 1'b1, 1'b1));
      drain();

      gains[0] = '{16'd0, 16'd0, 16'd0};
      gains[1] = '{16'hffff, 16'hffff, 16'hffff};
      gains[2] = '{16'd4096, 16'd400, 16'd3};
      gains[3] = '{16'd98, 16'hffff, 16'd0};
      gains[4] = '{16'd300, 16'd0, 16'd40};
      gains[5] = '{16'($urandom), 16'($urandom), 16'($urandom_range(200))};
      for (int ph = 0; ph < 6; ph++) begin
         write_gain(REG_KP, gains[ph][0]);
         write_gain(REG_KI, gains[ph][1]);
         write_gain(REG_KD, gains[ph][2]);
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
            default: begin send_idle_pct = 8; recv_stall_pct = 8; end
         endcase
         random_words(RANDOM_WORDS / 12);
         // Let the pipeline empty completely before continuing the phase.
         req_tvalid <= 1'b0;
         @(posedge clock);
         while (drive_model.pending.size() != 0) @(posedge clock);
         random_words(RANDOM_WORDS / 12);
         drain();
      end

      $display("covered %0d input words and %0d drive words over six gain settings",
               words_sent, words_checked);
      $display("gains included all-zero and all-ones, heading hold and precision mode");
      if (error_count == 0 && drive_model.pending.size() == 0) begin
         $display("three_axis_pid_drive_with_heading_hold_tb: clean");
      end else begin
         if (drive_model.pending.size() != 0)
            $display("%0d drive words never arrived", drive_model.pending.size());
         $display("three_axis_pid_drive_with_heading_hold_tb: errors");
      end
      $finish;
   end

endmodule

FILE: files.f
design/tpd_pkg.sv
design/tpd_mul.sv
design/tpd_div.sv
design/three_axis_pid_drive_with_heading_hold.sv
tb/three_axis_pid_drive_with_heading_hold_tb.sv
